### hw/rtl/cfss_pkg.sv
// Shared types, codes and sizes for the cyclic frame slot scheduler.
`timescale 1ns / 1ps
package cfss_pkg;

    localparam int SLOT_COUNT_MAX = 16;
    localparam int SLOT_IDX_W     = $clog2(SLOT_COUNT_MAX);
    localparam int SLOT_CNT_W     = $clog2(SLOT_COUNT_MAX + 1);
    localparam int DIV_W          = 32;
    localparam int DIV_CNT_W      = $clog2(DIV_W);
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [1:0] ACT_INIT     = 2'd0;
    localparam logic [1:0] ACT_REGISTER = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PARAM = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MAJOR_FRAME_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MINOR_FRAME_BUDGET_MS = 2'd1;

    localparam logic [15:0] MAJOR_FRAME_LENGTH_RST    = 16'd10;
    localparam logic [15:0] MINOR_FRAME_BUDGET_MS_RST = 16'd10;

    typedef struct packed {
        logic [1:0]  action;
        logic        slot_has_handler;
        logic [31:0] slot_rate;
        logic [7:0]  slot_offset;
        logic [15:0] elapsed_ms;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fired_mask;
        logic [4:0]  fired_count;
        logic [15:0] minor_phase;
        logic [31:0] major_count;
        logic        overrun;
    } out_word_t;

    typedef struct packed {
        logic [31:0] rate;
        logic [7:0]  offset;
    } slot_entry_t;

    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] addr;
        slot_entry_t           entry;
    } tbl_wr_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } rem_rsp_t;

endpackage

### hw/rtl/cfss_slot_table.sv
// Slot table memory: rate and offset per slot, one write and one registered read port.
`timescale 1ns / 1ps
module cfss_slot_table (
    input  logic                            clk,
    input  cfss_pkg::tbl_wr_t               wr,
    input  logic [cfss_pkg::SLOT_IDX_W-1:0] rd_addr,
    output cfss_pkg::slot_entry_t           rd_data
);

    cfss_pkg::slot_entry_t mem [cfss_pkg::SLOT_COUNT_MAX];
    cfss_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/cfss_rem_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module cfss_rem_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  cfss_pkg::rem_req_t req,
    output cfss_pkg::rem_rsp_t rsp
);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [cfss_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [cfss_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [cfss_pkg::DIV_W-1:0]     rem_reg;
    logic [cfss_pkg::DIV_W-1:0]     rem_next;
    logic [cfss_pkg::DIV_W-1:0]     dvd_reg;
    logic [cfss_pkg::DIV_W-1:0]     dvd_next;
    logic [cfss_pkg::DIV_W-1:0]     dvs_reg;
    logic [cfss_pkg::DIV_W-1:0]     dvs_next;
    logic [cfss_pkg::DIV_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[cfss_pkg::DIV_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = cfss_pkg::DIV_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[cfss_pkg::DIV_W-1:0];
            end
            dvd_next = {dvd_reg[cfss_pkg::DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == cfss_pkg::DIV_CNT_W'(cfss_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

### hw/rtl/cyclic_frame_slot_scheduler_unit.sv
// Top level of the cyclic frame slot scheduler: sequencer, counters and channels.
//
// Usage: one input word per action (init, register slot, tick) on in_valid/in_ready,
// one result word per action on out_valid/out_ready. Configuration writes go on
// cfg_valid/cfg_ready (always ready) with cfg_index 0 = major frame length,
// 1 = minor frame budget in ms; write them only while the block is idle.
// One word is processed at a time. Every remainder is taken by a single shared
// bit-serial unit: init, register and rejected actions need only the phase
// remainder, and a tick with N registered slots needs one per slot, one for the
// major frame wrap and one for the phase, one after another.
// The next word can be accepted in the cycle after the result is loaded.
// A new word is accepted as soon as the previous result sits in the output
// register; if the receiver stalls, the next result is held in the sequencer
// and no further word is accepted until the output register frees.
// Reset clears the counters, the slot count and the initialised flag, and sets
// both configuration registers to 10; the slot table contents are not cleared.
`timescale 1ns / 1ps
module cyclic_frame_slot_scheduler_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  cfss_pkg::in_word_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output cfss_pkg::out_word_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cfss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfss_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;
    localparam logic [3:0] S_SLOT   = 4'd2;
    localparam logic [3:0] S_SLOTW  = 4'd3;
    localparam logic [3:0] S_OLD    = 4'd4;
    localparam logic [3:0] S_OLDW   = 4'd5;
    localparam logic [3:0] S_PHASE  = 4'd6;
    localparam logic [3:0] S_PHASEW = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]                      state_reg;
    logic [3:0]                      state_next;
    logic [15:0]                     len_reg;
    logic [15:0]                     budget_reg;
    logic [cfss_pkg::SLOT_CNT_W-1:0] used_reg;
    logic [cfss_pkg::SLOT_CNT_W-1:0] used_next;
    logic [cfss_pkg::SLOT_CNT_W-1:0] idx_reg;
    logic [cfss_pkg::SLOT_CNT_W-1:0] idx_next;
    logic [31:0]                     minor_reg;
    logic [31:0]                     minor_next;
    logic [31:0]                     major_reg;
    logic [31:0]                     major_next;
    logic                            init_reg;
    logic                            init_next;
    logic                            ovr_reg;
    logic                            ovr_next;
    logic [1:0]                      status_reg;
    logic [1:0]                      status_next;
    logic [15:0]                     mask_reg;
    logic [15:0]                     mask_next;
    logic [4:0]                      count_reg;
    logic [4:0]                      count_next;
    logic [15:0]                     phase_reg;
    logic [15:0]                     phase_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    cfss_pkg::out_word_t             out_data_reg;
    cfss_pkg::out_word_t             out_data_next;

    logic [15:0]                     len_eff;
    logic                            in_fire;
    logic                            out_free;
    cfss_pkg::tbl_wr_t               tbl_wr;
    cfss_pkg::slot_entry_t           tbl_rd;
    cfss_pkg::rem_req_t              rem_req;
    cfss_pkg::rem_rsp_t              rem_rsp;

    cfss_slot_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (idx_reg[cfss_pkg::SLOT_IDX_W-1:0]),
        .rd_data (tbl_rd)
    );

    cfss_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    assign len_eff   = (len_reg == 16'd0) ? 16'd1 : len_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        minor_next     = minor_reg;
        major_next     = major_reg;
        init_next      = init_reg;
        ovr_next       = ovr_reg;
        status_next    = status_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        tbl_wr.en           = 1'b0;
        tbl_wr.addr         = used_reg[cfss_pkg::SLOT_IDX_W-1:0];
        tbl_wr.entry.rate   = in_data.slot_rate;
        tbl_wr.entry.offset = in_data.slot_offset;

        rem_req.start    = 1'b0;
        rem_req.dividend = minor_reg;
        rem_req.divisor  = {16'd0, len_eff};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = cfss_pkg::ST_OK;
                    mask_next   = '0;
                    count_next  = '0;
                    state_next  = S_PHASE;
                    case (in_data.action)
                        cfss_pkg::ACT_INIT:
                        begin
                            used_next  = '0;
                            minor_next = '0;
                            major_next = '0;
                            ovr_next   = 1'b0;
                            init_next  = 1'b1;
                        end
                        cfss_pkg::ACT_REGISTER:
                        begin
                            if (!in_data.slot_has_handler || in_data.slot_rate == 32'd0)
                            begin
                                status_next = cfss_pkg::ST_PARAM;
                            end
                            else if (used_reg >= cfss_pkg::SLOT_CNT_W'(cfss_pkg::SLOT_COUNT_MAX))
                            begin
                                status_next = cfss_pkg::ST_FULL;
                            end
                            else
                            begin
                                tbl_wr.en = 1'b1;
                                used_next = used_reg + 1'b1;
                            end
                        end
                        cfss_pkg::ACT_TICK:
                        begin
                            if (!init_reg)
                            begin
                                status_next = cfss_pkg::ST_PARAM;
                            end
                            else
                            begin
                                ovr_next   = (in_data.elapsed_ms >= budget_reg);
                                idx_next   = '0;
                                state_next = (used_reg == '0) ? S_OLD : S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = cfss_pkg::ST_PARAM;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                rem_req.start    = 1'b1;
                rem_req.dividend = minor_reg - {24'd0, tbl_rd.offset};
                rem_req.divisor  = tbl_rd.rate;
                state_next       = S_SLOTW;
            end
            S_SLOTW:
            begin
                if (rem_rsp.done)
                begin
                    if (rem_rsp.rem == 32'd0)
                    begin
                        mask_next  = mask_reg | (16'd1 << idx_reg[cfss_pkg::SLOT_IDX_W-1:0]);
                        count_next = count_reg + 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == used_reg) ? S_OLD : S_READ;
                end
            end
            S_OLD:
            begin
                rem_req.start = 1'b1;
                state_next    = S_OLDW;
            end
            S_OLDW:
            begin
                if (rem_rsp.done)
                begin
                    minor_next = minor_reg + 1'b1;
                    if (rem_rsp.rem == {16'd0, len_eff - 16'd1})
                    begin
                        major_next = major_reg + 1'b1;
                    end
                    state_next = S_PHASE;
                end
            end
            S_PHASE:
            begin
                rem_req.start = 1'b1;
                state_next    = S_PHASEW;
            end
            S_PHASEW:
            begin
                if (rem_rsp.done)
                begin
                    phase_next = rem_rsp.rem[15:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.status      = status_reg;
                    out_data_next.fired_mask  = mask_reg;
                    out_data_next.fired_count = count_reg;
                    out_data_next.minor_phase = phase_reg;
                    out_data_next.major_count = major_reg;
                    out_data_next.overrun     = ovr_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= cfss_pkg::MAJOR_FRAME_LENGTH_RST;
            budget_reg    <= cfss_pkg::MINOR_FRAME_BUDGET_MS_RST;
            used_reg      <= '0;
            idx_reg       <= '0;
            minor_reg     <= '0;
            major_reg     <= '0;
            init_reg      <= 1'b0;
            ovr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            minor_reg     <= minor_next;
            major_reg     <= major_next;
            init_reg      <= init_next;
            ovr_reg       <= ovr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == cfss_pkg::REG_MAJOR_FRAME_LENGTH)
                begin
                    len_reg <= cfg_data;
                end
                else if (cfg_index == cfss_pkg::REG_MINOR_FRAME_BUDGET_MS)
                begin
                    budget_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        mask_reg     <= mask_next;
        count_reg    <= count_next;
        phase_reg    <= phase_next;
        out_data_reg <= out_data_next;
    end

endmodule

### sim/tb_cyclic_frame_slot_scheduler_unit.sv
// Self-checking testbench for the cyclic frame slot scheduler: predicted results vs. DUT words.
`timescale 1ns / 1ps
module tb_cyclic_frame_slot_scheduler_unit;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 20000;
    localparam int         SETTLE_CYCLES = 700;
    localparam int         PHASES = 8;
    localparam int         WORDS_PER_PHASE = 125;

    class frame_schedule_board;
        logic [31:0]                         slot_rate_tbl [cfss_pkg::SLOT_COUNT_MAX];
        logic [7:0]                          slot_offset_tbl [cfss_pkg::SLOT_COUNT_MAX];
        logic [cfss_pkg::SLOT_COUNT_MAX-1:0] live_slots;
        int unsigned                         slots_used;
        logic [31:0]                         minor_ctr;
        logic [31:0]                         major_ctr;
        bit                                  started;
        bit                                  late_frame;
        logic [15:0]                         frame_len_reg;
        logic [15:0]                         budget_reg;
        cfss_pkg::out_word_t                 awaited_words [$];
        int unsigned                         fail_count;
        int unsigned                         results_seen;
        int unsigned                         firings;

        function new();
            live_slots    = '0;
            slots_used    = 0;
            minor_ctr     = '0;
            major_ctr     = '0;
            started       = 1'b0;
            late_frame    = 1'b0;
            frame_len_reg = cfss_pkg::MAJOR_FRAME_LENGTH_RST;
            budget_reg    = cfss_pkg::MINOR_FRAME_BUDGET_MS_RST;
            fail_count    = 0;
            results_seen  = 0;
            firings       = 0;
        endfunction

        function void write_reg(input logic [cfss_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [15:0] val);
            if (idx == cfss_pkg::REG_MAJOR_FRAME_LENGTH)
                frame_len_reg = val;
            else if (idx == cfss_pkg::REG_MINOR_FRAME_BUDGET_MS)
                budget_reg = val;
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction

        function logic [31:0] frame_length();
            return (frame_len_reg == 16'd0) ? 32'd1 : {16'd0, frame_len_reg};
        endfunction

        function void note_input(input cfss_pkg::in_word_t w);
            cfss_pkg::out_word_t r;
            logic [31:0]         len;
            logic [31:0]         phase;
            int                  i;
            r = '0;
            case (w.action)
                cfss_pkg::ACT_INIT:
                begin
                    live_slots = '0;
                    slots_used = 0;
                    minor_ctr  = '0;
                    major_ctr  = '0;
                    late_frame = 1'b0;
                    started    = 1'b1;
                end
                cfss_pkg::ACT_REGISTER:
                begin
                    if (!w.slot_has_handler || w.slot_rate == 32'd0)
                        r.status = cfss_pkg::ST_PARAM;
                    else if (slots_used >= cfss_pkg::SLOT_COUNT_MAX)
                        r.status = cfss_pkg::ST_FULL;
                    else
                    begin
                        slot_rate_tbl[slots_used]   = w.slot_rate;
                        slot_offset_tbl[slots_used] = w.slot_offset;
                        live_slots[slots_used]      = 1'b1;
                        slots_used++;
                    end
                end
                cfss_pkg::ACT_TICK:
                begin
                    if (!started)
                        r.status = cfss_pkg::ST_PARAM;
                    else
                    begin
                        len   = frame_length();
                        phase = minor_ctr % len;
                        for (i = 0; i < cfss_pkg::SLOT_COUNT_MAX; i++)
                        begin
                            if (live_slots[i] && slot_rate_tbl[i] != 32'd0 &&
                                ((minor_ctr - {24'd0, slot_offset_tbl[i]}) % slot_rate_tbl[i])
                                == 32'd0)
                            begin
                                r.fired_mask[i] = 1'b1;
                                if (r.fired_count < 5'd31)
                                    r.fired_count = r.fired_count + 5'd1;
                                firings++;
                            end
                        end
                        minor_ctr = minor_ctr + 32'd1;
                        if (phase == len - 32'd1)
                            major_ctr = major_ctr + 32'd1;
                        late_frame = (w.elapsed_ms >= budget_reg);
                    end
                end
                default:
                    r.status = cfss_pkg::ST_PARAM;
            endcase
            r.minor_phase = 16'(minor_ctr % frame_length());
            r.major_count = major_ctr;
            r.overrun     = late_frame;
            awaited_words.push_back(r);
        endfunction

        function void mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
            $display("%0t ns: %s mismatch, expected %0h got %0h", $time, field, want, got);
            fail_count++;
        endfunction

        function void check_result(input cfss_pkg::out_word_t got);
            cfss_pkg::out_word_t want;
            results_seen++;
            if (awaited_words.size() == 0)
            begin
                $display("%0t ns: result word with none expected, got %p", $time, got);
                fail_count++;
                return;
            end
            want = awaited_words.pop_front();
            if (got.status !== want.status)
                mismatch("status", 32'(want.status), 32'(got.status));
            if (got.fired_mask !== want.fired_mask)
                mismatch("fired_mask", 32'(want.fired_mask), 32'(got.fired_mask));
            if (got.fired_count !== want.fired_count)
                mismatch("fired_count", 32'(want.fired_count), 32'(got.fired_count));
            if (got.minor_phase !== want.minor_phase)
                mismatch("minor_phase", 32'(want.minor_phase), 32'(got.minor_phase));
            if (got.major_count !== want.major_count)
                mismatch("major_count", want.major_count, got.major_count);
            if (got.overrun !== want.overrun)
                mismatch("overrun", 32'(want.overrun), 32'(got.overrun));
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    cfss_pkg::in_word_t               in_data = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    cfss_pkg::out_word_t              out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [cfss_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cfss_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    frame_schedule_board sb;
    bit                  pace_on = 1'b1;
    int                  words_sent = 0;
    int                  settings_run = 0;
    int                  idle_cycles = 0;

    cyclic_frame_slot_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null && out_valid && out_ready)
            sb.check_result(out_data);
        out_ready <= !pace_on || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb_cyclic_frame_slot_scheduler_unit: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic cfss_pkg::in_word_t random_word();
        cfss_pkg::in_word_t w;
        w.action           = 2'($urandom_range(0, 3));
        w.slot_has_handler = 1'($urandom_range(0, 1));
        w.slot_rate        = $urandom();
        w.slot_offset      = 8'($urandom());
        w.elapsed_ms       = 16'($urandom());
        return w;
    endfunction

    function automatic cfss_pkg::in_word_t action_word(input logic [1:0] act);
        cfss_pkg::in_word_t w;
        w        = random_word();
        w.action = act;
        return w;
    endfunction

    function automatic cfss_pkg::in_word_t slot_word(input logic h, input logic [31:0] r,
                                                     input logic [7:0] o);
        cfss_pkg::in_word_t w;
        w                  = action_word(cfss_pkg::ACT_REGISTER);
        w.slot_has_handler = h;
        w.slot_rate        = r;
        w.slot_offset      = o;
        return w;
    endfunction

    function automatic cfss_pkg::in_word_t tick_word(input logic [15:0] e);
        cfss_pkg::in_word_t w;
        w            = action_word(cfss_pkg::ACT_TICK);
        w.elapsed_ms = e;
        return w;
    endfunction

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(0, 5))
            0: return sb.budget_reg - 16'd1;
            1: return sb.budget_reg;
            2: return sb.budget_reg + 16'd1;
            3: return 16'd0;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_word(input cfss_pkg::in_word_t w);
        if (pace_on && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 40);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_frame_regs(input logic [15:0] len, input logic [15:0] budget);
        cfg_valid <= 1'b1;
        cfg_index <= cfss_pkg::REG_MAJOR_FRAME_LENGTH;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(cfss_pkg::REG_MAJOR_FRAME_LENGTH, len);
        cfg_index <= cfss_pkg::REG_MINOR_FRAME_BUDGET_MS;
        cfg_data  <= budget;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(cfss_pkg::REG_MINOR_FRAME_BUDGET_MS, budget);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    task automatic run_directed();
        int k;
        send_word(tick_word(16'hFFFF));
        send_word(slot_word(1'b1, 32'd3, 8'd0));
        send_word(tick_word(16'd0));
        send_word(action_word(ACT_UNUSED));
        send_word(action_word(cfss_pkg::ACT_INIT));
        send_word(slot_word(1'b0, 32'd5, 8'd0));
        send_word(slot_word(1'b1, 32'd0, 8'd7));
        send_word(slot_word(1'b1, 32'hFFFF_FFFF, 8'hFF));
        send_word(slot_word(1'b1, 32'd1, 8'd0));
        for (k = 2; k < cfss_pkg::SLOT_COUNT_MAX; k++)
            send_word(slot_word(1'b1, 32'(k % 5 + 1), 8'(k * 17)));
        send_word(slot_word(1'b1, 32'd4, 8'd1));
        send_word(slot_word(1'b0, 32'd4, 8'd1));
        send_word(tick_word(16'd9));
        send_word(tick_word(16'd10));
        send_word(tick_word(16'hFFFF));
    endtask

    task automatic run_schedule();
        int                 n_slots;
        int                 n_ticks;
        int                 k;
        int                 roll;
        cfss_pkg::in_word_t w;
        send_word(action_word(cfss_pkg::ACT_INIT));
        roll = $urandom_range(0, 99);
        if (roll < 65)
            n_slots = $urandom_range(1, 6);
        else if (roll < 87)
            n_slots = $urandom_range(7, cfss_pkg::SLOT_COUNT_MAX);
        else if (roll < 95)
            n_slots = cfss_pkg::SLOT_COUNT_MAX + $urandom_range(1, 3);
        else
            n_slots = 0;
        for (k = 0; k < n_slots; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                w = slot_word(1'b1, 32'($urandom_range(1, 12)), 8'($urandom()));
            else if (roll < 88)
                w = slot_word(1'b1, $urandom(), 8'($urandom()));
            else if (roll < 94)
                w = slot_word(1'b0, 32'($urandom_range(1, 12)), 8'($urandom()));
            else
                w = slot_word(1'b1, 32'd0, 8'($urandom()));
            send_word(w);
        end
        n_ticks = $urandom_range(4, 40);
        for (k = 0; k < n_ticks; k++)
            send_word(tick_word(pick_elapsed()));
    endtask

    task automatic run_phase(input int n_words);
        int goal;
        goal = words_sent + n_words;
        while (words_sent < goal)
        begin
            if ($urandom_range(0, 99) < 85)
                run_schedule();
            else
                send_word(random_word());
        end
    endtask

    initial
    begin
        logic [15:0] len_set [PHASES];
        logic [15:0] budget_set [PHASES];
        int          p;
        len_set    = '{16'd1, 16'd0, 16'd65535, 16'd10, 16'd7, 16'd2,
                       16'($urandom_range(1, 20)), 16'($urandom())};
        budget_set = '{16'd1, 16'd0, 16'd65535, 16'd10, 16'd100, 16'd65534,
                       16'($urandom()), 16'($urandom_range(1, 50))};
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            pace_on = (p != 3);
            write_frame_regs(len_set[p], budget_set[p]);
            run_phase(WORDS_PER_PHASE);
        end
        pace_on = 1'b1;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Drove %0d words over %0d frame settings, checked %0d results.",
                 words_sent, settings_run, sb.results_seen);
        $display("Predicted %0d slot firings; %0d mismatches.", sb.firings, sb.fail_count);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("tb_cyclic_frame_slot_scheduler_unit: clean");
        else
            $display("tb_cyclic_frame_slot_scheduler_unit: errors");
        $finish;
    end

endmodule
